// ----- hw/rtl/set_union_intersection_top_macros.svh -----
`ifndef SET_UNION_INTERSECTION_TOP_MACROS_SVH
`define SET_UNION_INTERSECTION_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold on every clock edge outside reset
`define SUI_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never be seen outside reset
`define SUI_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define SUI_ASSERT(label, clk, rstn, prop, msg)
`define SUI_ASSERT_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

// ----- hw/rtl/sui_pkg.sv -----
package sui_pkg;

    localparam int DEF_MAX_ITEMS = 16;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 2;
    localparam int USER_OUT_W    = 4;

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    localparam logic [CMD_W-1:0] CMD_APPEND_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE  = 2'd2;

    typedef enum logic [1:0] {
        OP_APPEND_A,
        OP_APPEND_B,
        OP_COMPUTE
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [VALUE_W-1:0] value;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } push_t;

    // from the lowest bit: which_list, list_empty, last_in_list, overflowed
    typedef struct packed {
        logic overflowed;
        logic last_in_list;
        logic list_empty;
        logic which_list;
    } res_user_t;

endpackage

// ----- hw/rtl/sui_front.sv -----
module sui_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sui_pkg::VALUE_W-1:0]      s_tdata,   // value
    input  logic [sui_pkg::CMD_W-1:0]        s_tuser,   // command
    output sui_pkg::push_t                   push,
    input  logic                             push_ready
);

    logic              hold_valid_reg, hold_valid_next;
    sui_pkg::q_entry_t hold_entry_reg, hold_entry_next;
    logic              accept;
    logic              known_cmd;
    sui_pkg::op_t      op_dec;

    // classify the command, unused codes are dropped here
    always_comb begin
        known_cmd = 1'b1;
        op_dec    = sui_pkg::OP_COMPUTE;
        case (s_tuser)
            sui_pkg::CMD_APPEND_A: begin
                op_dec = sui_pkg::OP_APPEND_A;
            end
            sui_pkg::CMD_APPEND_B: begin
                op_dec = sui_pkg::OP_APPEND_B;
            end
            sui_pkg::CMD_COMPUTE: begin
                op_dec = sui_pkg::OP_COMPUTE;
            end
            default: begin
                known_cmd = 1'b0;
            end
        endcase
    end

    assign s_tready = !hold_valid_reg || push_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        hold_valid_next = hold_valid_reg && !push_ready;
        hold_entry_next = hold_entry_reg;
        if (accept) begin
            hold_valid_next       = known_cmd;
            hold_entry_next.op    = op_dec;
            hold_entry_next.value = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_entry_reg <= hold_entry_next;
    end

    assign push.valid = hold_valid_reg;
    assign push.entry = hold_entry_reg;

endmodule

// ----- hw/rtl/sui_queue.sv -----
module sui_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  sui_pkg::push_t    push,
    output logic              push_ready,
    output logic              q_valid,
    output sui_pkg::q_entry_t q_entry,
    input  logic              q_pop
);

    sui_pkg::q_entry_t                slots_reg [sui_pkg::QUEUE_DEPTH];
    logic [sui_pkg::QUEUE_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [sui_pkg::QUEUE_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [sui_pkg::QUEUE_AW:0]       fill_reg, fill_next;
    logic                             do_push, do_pop;

    assign push_ready = (fill_reg != (sui_pkg::QUEUE_AW+1)'(sui_pkg::QUEUE_DEPTH));
    assign q_valid    = (fill_reg != '0);
    assign q_entry    = slots_reg[rd_ptr_reg];
    assign do_push    = push.valid && push_ready;
    assign do_pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ----- hw/rtl/sui_back.sv -----
`include "set_union_intersection_top_macros.svh"

module sui_back #(
    parameter int MAX_ITEMS = sui_pkg::DEF_MAX_ITEMS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  sui_pkg::q_entry_t                q_entry,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sui_pkg::VALUE_W-1:0]      m_tdata,
    output logic [sui_pkg::USER_OUT_W-1:0]   m_tuser,
    output logic                             m_tlast
);

    localparam int AW  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int NUW = $clog2(2 * MAX_ITEMS + 1);
    localparam int VW  = sui_pkg::VALUE_W;
    localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);

    typedef enum logic [3:0] {
        B_IDLE,
        B_SNEXT,
        B_FETCH,
        B_HOLD,
        B_INNER,
        B_ENEXT,
        B_EFETCH,
        B_ESEND,
        B_DONE
    } state_t;

    typedef enum logic [1:0] {
        EP_INTER,
        EP_UNA,
        EP_UNB
    } ephase_t;

    // element stores and per-element flags
    logic [VW-1:0] list_a_mem [MAX_ITEMS];
    logic [VW-1:0] list_b_mem [MAX_ITEMS];
    logic [1:0]    flag_a_mem [MAX_ITEMS];
    logic          flag_b_mem [MAX_ITEMS];

    logic [VW-1:0] rdata_a_reg, rdata_b_reg;
    logic [1:0]    rflag_a_reg;
    logic          rflag_b_reg;

    state_t              state_reg, state_next;
    ephase_t             ph_reg, ph_next;
    logic [CW-1:0]       na_reg, na_next;
    logic [CW-1:0]       nb_reg, nb_next;
    logic                ovf_reg, ovf_next;
    logic [CW-1:0]       o_reg, o_next;
    logic                sel_reg, sel_next;
    logic [VW-1:0]       v_reg, v_next;
    logic [CW-1:0]       k_reg, k_next;
    logic                pend_reg, pend_next;
    logic [CW-1:0]       pidx_reg, pidx_next;
    logic                dup_reg, dup_next;
    logic                hit_reg, hit_next;
    logic [CW-1:0]       ni_reg, ni_next;
    logic [NUW-1:0]      nu_reg, nu_next;
    logic [CW-1:0]       ci_reg, ci_next;
    logic [NUW-1:0]      cu_reg, cu_next;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [VW-1:0]       m_tdata_reg, m_tdata_next;
    sui_pkg::res_user_t  m_tuser_reg, m_tuser_next;
    logic                m_tlast_reg, m_tlast_next;

    logic [AW-1:0] rd_addr;
    logic          we_a, we_b, we_fa, we_fb;
    logic [AW-1:0] wa_addr, wb_addr, wf_addr;
    logic [1:0]    fa_wdata;
    logic          fb_wdata;

    logic [CW-1:0] other_cnt;
    logic [CW-1:0] lim;
    logic [VW-1:0] same_word, other_word;
    logic          slot_free;
    logic          first_a, inter_a, new_b;
    logic [CW-1:0] o_inc, ci_inc;
    logic [NUW-1:0] cu_inc;
    logic          want;
    logic [VW-1:0] emit_word;

    assign rd_addr    = (state_reg == B_INNER) ? k_reg[AW-1:0] : o_reg[AW-1:0];
    assign other_cnt  = sel_reg ? na_reg : nb_reg;
    assign lim        = (o_reg > other_cnt) ? o_reg : other_cnt;
    assign same_word  = sel_reg ? rdata_b_reg : rdata_a_reg;
    assign other_word = sel_reg ? rdata_a_reg : rdata_b_reg;
    assign slot_free  = !m_tvalid_reg || m_tready;
    assign first_a    = !dup_reg;
    assign inter_a    = !dup_reg && hit_reg;
    assign new_b      = !dup_reg && !hit_reg;
    assign o_inc      = o_reg + 1'b1;
    assign ci_inc     = ci_reg + 1'b1;
    assign cu_inc     = cu_reg + 1'b1;
    assign emit_word  = (ph_reg == EP_UNB) ? rdata_b_reg : rdata_a_reg;
    assign q_pop      = (state_reg == B_IDLE) && q_valid;

    always_comb begin
        case (ph_reg)
            EP_INTER: want = rflag_a_reg[1];
            EP_UNA:   want = rflag_a_reg[0];
            EP_UNB:   want = rflag_b_reg;
            default:  want = 1'b0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        ph_next       = ph_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        ovf_next      = ovf_reg;
        o_next        = o_reg;
        sel_next      = sel_reg;
        v_next        = v_reg;
        k_next        = k_reg;
        pend_next     = 1'b0;
        pidx_next     = k_reg;
        dup_next      = dup_reg;
        hit_next      = hit_reg;
        ni_next       = ni_reg;
        nu_next       = nu_reg;
        ci_next       = ci_reg;
        cu_next       = cu_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        we_a          = 1'b0;
        we_b          = 1'b0;
        we_fa         = 1'b0;
        we_fb         = 1'b0;
        wa_addr       = na_reg[AW-1:0];
        wb_addr       = nb_reg[AW-1:0];
        wf_addr       = o_reg[AW-1:0];
        fa_wdata      = {inter_a, first_a};
        fb_wdata      = new_b;

        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    case (q_entry.op)
                        sui_pkg::OP_APPEND_A: begin
                            if (na_reg < CAP) begin
                                we_a    = 1'b1;
                                na_next = na_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        sui_pkg::OP_APPEND_B: begin
                            if (nb_reg < CAP) begin
                                we_b    = 1'b1;
                                nb_next = nb_reg + 1'b1;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        sui_pkg::OP_COMPUTE: begin
                            sel_next   = 1'b0;
                            o_next     = '0;
                            ni_next    = '0;
                            nu_next    = '0;
                            ci_next    = '0;
                            cu_next    = '0;
                            state_next = B_SNEXT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_SNEXT: begin
                if (!sel_reg) begin
                    if (o_reg < na_reg) begin
                        state_next = B_FETCH;
                    end else begin
                        sel_next = 1'b1;
                        o_next   = '0;
                    end
                end else begin
                    if (o_reg < nb_reg) begin
                        state_next = B_FETCH;
                    end else begin
                        o_next     = '0;
                        ph_next    = EP_INTER;
                        ci_next    = '0;
                        cu_next    = '0;
                        state_next = B_ENEXT;
                    end
                end
            end
            B_FETCH: begin
                state_next = B_HOLD;
            end
            B_HOLD: begin
                v_next     = same_word;
                k_next     = '0;
                dup_next   = 1'b0;
                hit_next   = 1'b0;
                state_next = B_INNER;
            end
            B_INNER: begin
                // compare stage for the word read last cycle
                if (pend_reg && (pidx_reg < o_reg) && (same_word == v_reg)) begin
                    dup_next = 1'b1;
                end
                if (pend_reg && (pidx_reg < other_cnt) && (other_word == v_reg)) begin
                    hit_next = 1'b1;
                end
                if (k_reg < lim) begin
                    pend_next = 1'b1;
                    k_next    = k_reg + 1'b1;
                end else if (!pend_reg) begin
                    if (!sel_reg) begin
                        we_fa   = 1'b1;
                        ni_next = ni_reg + CW'(inter_a);
                        nu_next = nu_reg + NUW'(first_a);
                    end else begin
                        we_fb   = 1'b1;
                        nu_next = nu_reg + NUW'(new_b);
                    end
                    o_next     = o_inc;
                    state_next = B_SNEXT;
                end
            end
            B_ENEXT: begin
                case (ph_reg)
                    EP_INTER: begin
                        if (ni_reg == '0) begin
                            if (slot_free) begin
                                m_tvalid_next             = 1'b1;
                                m_tdata_next              = '0;
                                m_tuser_next.which_list   = 1'b0;
                                m_tuser_next.list_empty   = 1'b1;
                                m_tuser_next.last_in_list = 1'b1;
                                m_tuser_next.overflowed   = ovf_reg;
                                m_tlast_next              = 1'b0;
                                ph_next                   = EP_UNA;
                                o_next                    = '0;
                            end
                        end else if (o_reg < na_reg) begin
                            state_next = B_EFETCH;
                        end else begin
                            ph_next = EP_UNA;
                            o_next  = '0;
                        end
                    end
                    EP_UNA: begin
                        if (nu_reg == '0) begin
                            if (slot_free) begin
                                m_tvalid_next             = 1'b1;
                                m_tdata_next              = '0;
                                m_tuser_next.which_list   = 1'b1;
                                m_tuser_next.list_empty   = 1'b1;
                                m_tuser_next.last_in_list = 1'b1;
                                m_tuser_next.overflowed   = ovf_reg;
                                m_tlast_next              = 1'b1;
                                state_next                = B_DONE;
                            end
                        end else if (o_reg < na_reg) begin
                            state_next = B_EFETCH;
                        end else begin
                            ph_next = EP_UNB;
                            o_next  = '0;
                        end
                    end
                    default: begin
                        if (o_reg < nb_reg) begin
                            state_next = B_EFETCH;
                        end else begin
                            state_next = B_DONE;
                        end
                    end
                endcase
            end
            B_EFETCH: begin
                state_next = B_ESEND;
            end
            B_ESEND: begin
                if (!want) begin
                    o_next     = o_inc;
                    state_next = B_ENEXT;
                end else if (slot_free) begin
                    m_tvalid_next           = 1'b1;
                    m_tdata_next            = emit_word;
                    m_tuser_next.list_empty = 1'b0;
                    m_tuser_next.overflowed = ovf_reg;
                    if (ph_reg == EP_INTER) begin
                        m_tuser_next.which_list   = 1'b0;
                        m_tuser_next.last_in_list = (ci_inc == ni_reg);
                        m_tlast_next              = 1'b0;
                        ci_next                   = ci_inc;
                    end else begin
                        m_tuser_next.which_list   = 1'b1;
                        m_tuser_next.last_in_list = (cu_inc == nu_reg);
                        m_tlast_next              = (cu_inc == nu_reg);
                        cu_next                   = cu_inc;
                    end
                    o_next     = o_inc;
                    state_next = B_ENEXT;
                end
            end
            B_DONE: begin
                na_next    = '0;
                nb_next    = '0;
                ovf_next   = 1'b0;
                state_next = B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= B_IDLE;
            ph_reg       <= EP_INTER;
            na_reg       <= '0;
            nb_reg       <= '0;
            ovf_reg      <= 1'b0;
            o_reg        <= '0;
            sel_reg      <= 1'b0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            ni_reg       <= '0;
            nu_reg       <= '0;
            ci_reg       <= '0;
            cu_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            ovf_reg      <= ovf_next;
            o_reg        <= o_next;
            sel_reg      <= sel_next;
            k_reg        <= k_next;
            pend_reg     <= pend_next;
            ni_reg       <= ni_next;
            nu_reg       <= nu_next;
            ci_reg       <= ci_next;
            cu_reg       <= cu_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        v_reg       <= v_next;
        pidx_reg    <= pidx_next;
        dup_reg     <= dup_next;
        hit_reg     <= hit_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (we_a) begin
            list_a_mem[wa_addr] <= q_entry.value;
        end
        if (we_b) begin
            list_b_mem[wb_addr] <= q_entry.value;
        end
        if (we_fa) begin
            flag_a_mem[wf_addr] <= fa_wdata;
        end
        if (we_fb) begin
            flag_b_mem[wf_addr] <= fb_wdata;
        end
        rdata_a_reg <= list_a_mem[rd_addr];
        rdata_b_reg <= list_b_mem[rd_addr];
        rflag_a_reg <= flag_a_mem[rd_addr];
        rflag_b_reg <= flag_b_mem[rd_addr];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `SUI_ASSERT(a_count_cap, aclk, aresetn, (na_reg <= CAP) && (nb_reg <= CAP), "list count above capacity")
    `SUI_ASSERT(a_inter_count, aclk, aresetn, ci_reg <= ni_reg, "more intersection items than found")
    `SUI_ASSERT(a_tlast_union, aclk, aresetn, (m_tvalid_reg && m_tlast_reg) |-> (m_tuser_reg.which_list && m_tuser_reg.last_in_list), "run end not on last union item")
    `SUI_ASSERT(a_clear_after_run, aclk, aresetn, (state_reg == B_DONE) |=> ((na_reg == '0) && (nb_reg == '0) && !ovf_reg), "lists not cleared after compute")
    `SUI_ASSERT_NEVER(a_pop_busy, aclk, aresetn, q_pop && (state_reg != B_IDLE), "queue popped while busy")

endmodule

// ----- hw/rtl/set_union_intersection_top.sv -----
// appends: handled in the executer while it is idle; an accepted item passes the front hold register
// and the queue to reach it. compute: the scan of each stored element reads both element stores up to
// the larger of its index and the other list's count, through the single read port of each store;
// emit then sends each flagged element. A compute keeps the next queued item waiting until it is done
// sync active-low reset clears counts, overflow flag, queue and output valid; stores are not cleared
module set_union_intersection_top #(
    parameter int MAX_ITEMS = sui_pkg::DEF_MAX_ITEMS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sui_pkg::VALUE_W-1:0]        s_tdata,   // value
    input  logic [sui_pkg::CMD_W-1:0]          s_tuser,   // command
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sui_pkg::VALUE_W-1:0]        m_tdata,   // value_res
    output logic [sui_pkg::USER_OUT_W-1:0]     m_tuser,   // which_list, list_empty, last_in_list, overflowed
    output logic                               m_tlast
);

    sui_pkg::push_t    push;
    logic              push_ready;
    logic              q_valid;
    sui_pkg::q_entry_t q_entry;
    logic              q_pop;

    sui_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push       (push),
        .push_ready (push_ready)
    );

    sui_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_ready (push_ready),
        .q_valid    (q_valid),
        .q_entry    (q_entry),
        .q_pop      (q_pop)
    );

    sui_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
